// ----- rtl/celt_pkg.sv -----
`default_nettype none
package celt_pkg;

  typedef enum logic [2:0] {
    OP_ADD_VERTEX  = 3'd0,
    OP_ADD_EDGE    = 3'd1,
    OP_DROP_VERTEX = 3'd2,
    OP_DROP_SLOT   = 3'd3,
    OP_DROP_PAIR   = 3'd4,
    OP_FIND_VERTEX = 3'd5,
    OP_FIND_EDGE   = 3'd6,
    OP_NONE        = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_VTX,
    S_OUT
  } state_e;

  localparam int unsigned OpBits     = 3;
  localparam int unsigned VertexBits = 8;
  localparam int unsigned InWBits    = 32;
  localparam int unsigned SlotBits   = 6;
  localparam int unsigned TotalBits  = 7;
  localparam int unsigned StatusBits = 2;

endpackage
`default_nettype wire

// ----- rtl/celt_edge_mem.sv -----
`default_nettype none
module celt_edge_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 48,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output      logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/celt_vertex_mem.sv -----
`default_nettype none
module celt_vertex_mem #(
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic                wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output      logic                rdata_o
);

  logic mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/compacting_edge_list_table_unit.sv -----
`default_nettype none
// Edge list table with vertex presence bitmap. One command beat in, one
// result beat out. Add edge writes the edge and marks the first vertex,
// then marks the second vertex and counts the edge; a full table skips
// both steps. Drop vertex, drop slot, drop pair and find edge sweep
// the edge memory one entry per cycle through the single read port of
// the edge memory. A drop slot that is out of range skips the sweep.
// After reset the vertex bitmap memory is cleared one entry per cycle,
// during which no command beat is taken. A new command is taken while the
// previous result still waits on the output.
module compacting_edge_list_table_unit #(
  parameter int unsigned MAX_EDGES    = 64,
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned WEIGHT_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // op[2:0], first_vertex[10:3], second_vertex[18:11], weight_in[50:19],
  // slot_in[56:51], zero fill
  input  wire logic [63:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // found[0], slot_out[6:1], weight_out[38:7], edge_total[45:39],
  // status[47:46]
  output      logic [47:0] m_axis_tdata
);

  localparam int unsigned AB  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CB  = $clog2(MAX_EDGES + 1);
  localparam int unsigned VB  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned VCB = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW  = 2 * celt_pkg::VertexBits + WEIGHT_BITS;

  celt_pkg::state_e state_q, state_d;
  logic [celt_pkg::OpBits-1:0]     op_q, op_d;
  logic [celt_pkg::VertexBits-1:0] va_q, va_d, vb_q, vb_d;
  logic [WEIGHT_BITS-1:0]          w_q, w_d;
  logic [celt_pkg::SlotBits-1:0]   sl_q, sl_d;
  logic [CB-1:0] cnt_q, cnt_d, rd_q, rd_d, wr_q, wr_d;
  logic          rdv_q, rdv_d;
  logic [VCB-1:0] clr_q, clr_d;
  logic          busy_q, busy_d;
  logic          ov_q, ov_d;
  logic [47:0]   od_q, od_d;
  logic          fnd_q, fnd_d;
  logic [celt_pkg::SlotBits-1:0] fs_q, fs_d;
  logic [31:0]   fw_q, fw_d;

  logic          e_we;
  logic [AB-1:0] e_wa, e_ra;
  logic [EW-1:0] e_wd, e_rd;
  logic          v_we, v_wd, v_rd;
  logic [VB-1:0] v_wa, v_ra;

  celt_edge_mem #(.Depth(MAX_EDGES), .Width(EW)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd),
    .raddr_i(e_ra), .rdata_o(e_rd)
  );

  celt_vertex_mem #(.Depth(MAX_VERTICES)) u_vtx (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd),
    .raddr_i(v_ra), .rdata_o(v_rd)
  );

  logic [celt_pkg::VertexBits-1:0] r_src, r_dst;
  logic [WEIGHT_BITS-1:0]          r_w;
  assign r_src = e_rd[celt_pkg::VertexBits-1:0];
  assign r_dst = e_rd[2*celt_pkg::VertexBits-1:celt_pkg::VertexBits];
  assign r_w   = e_rd[EW-1:2*celt_pkg::VertexBits];

  logic signed [celt_pkg::InWBits-1:0] win;
  logic signed [WEIGHT_BITS-1:0] wfit;
  assign win = s_axis_tdata[50:19];
  always_comb begin
    if (WEIGHT_BITS >= 32) begin
      wfit = WEIGHT_BITS'(win);
    end else if (win > 32'(signed'({1'b0, {(WEIGHT_BITS-1){1'b1}}}))) begin
      wfit = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    end else if (win < 32'(signed'({1'b1, {(WEIGHT_BITS-1){1'b0}}}))) begin
      wfit = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    end else begin
      wfit = WEIGHT_BITS'(win);
    end
  end

  logic hit;
  always_comb begin
    if (op_q == celt_pkg::OP_DROP_VERTEX) begin
      hit = (r_src == va_q) || (r_dst == va_q);
    end else if (op_q == celt_pkg::OP_DROP_SLOT) begin
      hit = ((CB+1)'(rd_q) == (CB+1)'(sl_q) + (CB+1)'(1));
    end else begin
      hit = (r_src == va_q) && (r_dst == vb_q);
    end
  end

  logic vin_range;
  assign vin_range = (32'(va_q) < 32'(MAX_VERTICES));

  logic slot_oor;
  assign slot_oor = (32'(sl_q) >= 32'(cnt_q));

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == celt_pkg::S_IDLE) && !busy_q;

  function automatic logic [47:0] pack(logic f, logic [celt_pkg::SlotBits-1:0] s,
                                       logic [31:0] w, logic [CB-1:0] c,
                                       celt_pkg::status_e st);
    return {st, celt_pkg::TotalBits'(c), w, s, f};
  endfunction

  always_comb begin
    state_d = state_q; op_d = op_q; va_d = va_q; vb_d = vb_q; w_d = w_q;
    sl_d = sl_q; cnt_d = cnt_q; rd_d = rd_q; wr_d = wr_q; rdv_d = 1'b0;
    clr_d = clr_q; busy_d = busy_q; ov_d = ov_q; od_d = od_q;
    fnd_d = fnd_q; fs_d = fs_q; fw_d = fw_q;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
    v_we = 1'b0; v_wa = '0; v_wd = 1'b0; v_ra = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    if (busy_q) begin
      v_we = 1'b1; v_wa = VB'(clr_q);
      clr_d = clr_q + VCB'(1);
      if (clr_q == VCB'(MAX_VERTICES - 1)) busy_d = 1'b0;
    end
    unique case (state_q)
      celt_pkg::S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          op_d = s_axis_tdata[2:0];
          va_d = s_axis_tdata[10:3];
          vb_d = s_axis_tdata[18:11];
          w_d  = wfit;
          sl_d = s_axis_tdata[56:51];
          rd_d = '0; wr_d = '0; fnd_d = 1'b0; fs_d = '0; fw_d = '0;
          state_d = celt_pkg::S_SCAN;
          if (s_axis_tdata[2:0] == celt_pkg::OP_FIND_VERTEX) begin
            v_ra = VB'(s_axis_tdata[10:3]);
            state_d = celt_pkg::S_VTX;
          end
        end
      end
      celt_pkg::S_VTX: begin
        fnd_d = v_rd && vin_range;
        state_d = celt_pkg::S_OUT;
      end
      celt_pkg::S_SCAN: begin
        case (op_q)
          celt_pkg::OP_ADD_VERTEX: begin
            v_we = vin_range; v_wa = VB'(va_q); v_wd = 1'b1;
            state_d = celt_pkg::S_OUT;
          end
          celt_pkg::OP_ADD_EDGE: begin
            if (cnt_q < CB'(MAX_EDGES)) begin
              if (rd_q == '0) begin
                e_we = 1'b1; e_wa = AB'(cnt_q); e_wd = {w_q, vb_q, va_q};
                v_we = vin_range; v_wa = VB'(va_q); v_wd = 1'b1;
                rd_d = CB'(1);
              end else begin
                v_we = (32'(vb_q) < 32'(MAX_VERTICES)); v_wa = VB'(vb_q);
                v_wd = 1'b1;
                cnt_d = cnt_q + CB'(1);
                state_d = celt_pkg::S_OUT;
              end
            end else begin
              state_d = celt_pkg::S_OUT;
            end
          end
          celt_pkg::OP_DROP_VERTEX, celt_pkg::OP_DROP_SLOT,
          celt_pkg::OP_DROP_PAIR, celt_pkg::OP_FIND_EDGE: begin
            // one read per cycle, process the previous read
            if (rdv_q) begin
              if (op_q == celt_pkg::OP_FIND_EDGE) begin
                if (hit && !fnd_q) begin
                  fnd_d = 1'b1; fs_d = celt_pkg::SlotBits'(rd_q - CB'(1));
                  fw_d = 32'(signed'(r_w));
                end
              end else if (!hit) begin
                e_we = 1'b1; e_wa = AB'(wr_q); e_wd = e_rd;
                wr_d = wr_q + CB'(1);
              end
            end
            if (op_q == celt_pkg::OP_DROP_SLOT && slot_oor) begin
              state_d = celt_pkg::S_OUT;
            end else if (rd_q < cnt_q) begin
              e_ra = AB'(rd_q); rd_d = rd_q + CB'(1); rdv_d = 1'b1;
            end else begin
              if (op_q != celt_pkg::OP_FIND_EDGE) begin
                cnt_d = rdv_q && !hit ? wr_q + CB'(1) : wr_q;
              end
              if (op_q == celt_pkg::OP_DROP_VERTEX) begin
                state_d = celt_pkg::S_VTX;
              end else begin
                state_d = celt_pkg::S_OUT;
              end
            end
          end
          default: state_d = celt_pkg::S_OUT;
        endcase
        if (op_q == celt_pkg::OP_DROP_VERTEX && state_d == celt_pkg::S_VTX) begin
          v_we = vin_range; v_wa = VB'(va_q); v_wd = 1'b0;
          state_d = celt_pkg::S_OUT;
        end
      end
      celt_pkg::S_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;
          od_d = pack(fnd_q, fs_q, fw_q, cnt_q,
                      (op_q == celt_pkg::OP_ADD_EDGE && rd_q == '0) ? celt_pkg::ST_FULL :
                      (op_q == celt_pkg::OP_DROP_SLOT && slot_oor &&
                       wr_q == '0 && rd_q == '0) ? celt_pkg::ST_RANGE : celt_pkg::ST_OK);
          state_d = celt_pkg::S_IDLE;
        end
      end
      default: state_d = celt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= celt_pkg::S_IDLE;
      cnt_q <= '0; rdv_q <= 1'b0; clr_q <= '0; busy_q <= 1'b1; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; rdv_q <= rdv_d; clr_q <= clr_d; busy_q <= busy_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; va_q <= va_d; vb_q <= vb_d; w_q <= w_d; sl_q <= sl_d;
    rd_q <= rd_d; wr_q <= wr_d; od_q <= od_d; fnd_q <= fnd_d; fs_q <= fs_d;
    fw_q <= fw_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(MAX_EDGES)) else $error("edge count overflow");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready) else $error("beat taken during clear");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !m_axis_tready |=> ov_q && $stable(od_q)) else $error("result lost");
`endif

endmodule
`default_nettype wire
